/* rtl/eae_pkg.sv */
// Shared types, constants and permutation functions for the Elephant AEAD engine.
package eae_pkg;

  localparam int BLK_BYTES   = 20;
  localparam int BLK_BITS    = 8 * BLK_BYTES;
  localparam int NONCE_BYTES = 12;
  localparam int KEY_BYTES   = 16;
  localparam int TAG_BYTES   = 8;
  localparam int ROUNDS      = 80;
  localparam int FILL_W      = 5;
  localparam int RND_W       = 7;
  localparam int TAG_CNT_W   = $clog2(TAG_BYTES + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [6:0] CTR_INIT = 7'h75;
  localparam logic [7:0] PAD_BYTE = 8'h01;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_AD    = 2'd1,
    OP_TEXT  = 2'd2,
    OP_FIN   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LO   = 3'd0,
    CFG_KEY_HI   = 3'd1,
    CFG_NONCE_LO = 3'd2,
    CFG_NONCE_HI = 3'd3,
    CFG_DECRYPT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_NONCE = 2'd1,
    PH_AD    = 2'd2,
    PH_TEXT  = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_KEYP, S_ADP, S_DISP, S_KSP, S_TXT, S_CBP, S_TGP, S_EMIT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [8*KEY_BYTES-1:0]   key;
    logic [8*NONCE_BYTES-1:0] nonce;
    logic                     decrypt;
  } cfg_t;

  function automatic logic [3:0] sbox4(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'hE;  4'h1: y = 4'hD;  4'h2: y = 4'hB;  4'h3: y = 4'h0;
      4'h4: y = 4'h2;  4'h5: y = 4'h1;  4'h6: y = 4'h4;  4'h7: y = 4'hF;
      4'h8: y = 4'h7;  4'h9: y = 4'hA;  4'hA: y = 4'h8;  4'hB: y = 4'h5;
      4'hC: y = 4'h9;  4'hD: y = 4'hC;  4'hE: y = 4'h3;  default: y = 4'h6;
    endcase
    return y;
  endfunction

  function automatic logic [6:0] ctr_next(input logic [6:0] c);
    return {c[5:0], c[6] ^ c[5]};
  endfunction

  function automatic logic [BLK_BITS-1:0] perm_round(input logic [BLK_BITS-1:0] s,
                                                     input logic [6:0] c);
    logic [BLK_BITS-1:0] t;
    logic [BLK_BITS-1:0] p;
    int dst;
    t = s;
    t[7:0] = t[7:0] ^ {1'b0, c};
    for (int j = 0; j < 7; j++) begin
      t[BLK_BITS-1-j] = t[BLK_BITS-1-j] ^ c[j];
    end
    for (int i = 0; i < 2 * BLK_BYTES; i++) begin
      t[4*i +: 4] = sbox4(t[4*i +: 4]);
    end
    p = '0;
    for (int k = 0; k < BLK_BITS; k++) begin
      dst = (k == BLK_BITS - 1) ? k : (k * 40) % (BLK_BITS - 1);
      p[dst] = t[k];
    end
    return p;
  endfunction

  function automatic logic [BLK_BITS-1:0] lfsr_step(input logic [BLK_BITS-1:0] s);
    logic [BLK_BITS-1:0] t;
    logic [7:0] b0;
    t  = s >> 8;
    b0 = s[7:0];
    t[BLK_BITS-1 -: 8] = {b0[4:0], b0[7:5]} ^ {s[24], 7'b0} ^ {7'b0, s[8*13+7]};
    return t;
  endfunction

  function automatic logic [BLK_BITS-1:0] pad_blk(input logic [BLK_BITS-1:0] b,
                                                  input logic [FILL_W-1:0] fill);
    logic [BLK_BITS-1:0] r;
    for (int i = 0; i < BLK_BYTES; i++) begin
      if (i < int'(fill)) r[8*i +: 8] = b[8*i +: 8];
      else if (i == int'(fill)) r[8*i +: 8] = PAD_BYTE;
      else r[8*i +: 8] = 8'h00;
    end
    return r;
  endfunction

endpackage

/* rtl/elephant_aead_engine.sv */
// Elephant (Dumbo) AEAD engine top level: config registers, front queue and back end.
// Items are byte beats with an opcode on s_tuser. One Spongent-pi[160] unit running one
// round per cycle sets the timing: each permutation takes 80 rounds plus a handoff. A
// start runs the key permutation; an AD byte runs one only when it completes a 20-byte
// block; a text byte runs one on the first byte of each block (key stream) and one on
// the last (ciphertext fold); a finish runs the fold and tag permutations and then
// emits 8 tag beats, with one permutation more when it closes a later AD block. The
// input queue holds 4 beats so short bursts are taken while a permutation runs.
module elephant_aead_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // data_byte
  input  logic [1:0]                        s_tuser,   // opcode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,   // out_byte
  output logic [0:0]                        m_tuser,   // is_tag
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [eae_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [eae_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import eae_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid, item_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KEY_LO:   cfg.key[63:0]    <= cfg_data;
        CFG_KEY_HI:   cfg.key[127:64]  <= cfg_data;
        CFG_NONCE_LO: cfg.nonce[63:0]  <= cfg_data;
        CFG_NONCE_HI: cfg.nonce[95:64] <= cfg_data[31:0];
        CFG_DECRYPT:  cfg.decrypt      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  eae_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  eae_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_tag    (m_tuser[0]),
    .out_last   (m_tlast)
  );

endmodule

/* rtl/eae_front.sv */
// Input side: decodes stream beats into items and queues them for the back end.
module eae_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // data_byte
  input  logic [1:0]      s_tuser,   // opcode
  output logic            item_valid,
  input  logic            item_ready,
  output eae_pkg::item_t  item
);
  import eae_pkg::*;

  item_t             q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  item_t             beat;

  always_comb begin
    beat.op   = op_t'(s_tuser);
    beat.data = s_tdata;
  end

  assign s_tready   = (count != QCNT_W'(QUEUE_DEPTH));
  assign item_valid = (count != '0);
  assign item       = q[rptr];
  assign push       = s_tvalid && s_tready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) q[wptr] <= beat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !item_valid)
    else $error("item offered from empty queue");
  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");

endmodule

/* rtl/eae_perm.sv */
// Spongent-pi[160] permutation unit, one round per cycle.
module eae_perm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [eae_pkg::BLK_BITS-1:0] din,
  output logic                         busy,
  output logic                         done,
  output logic [eae_pkg::BLK_BITS-1:0] dout
);
  import eae_pkg::*;

  logic [BLK_BITS-1:0] st;
  logic [6:0]          ctr;
  logic [RND_W-1:0]    rnd;

  assign dout = st;

  always_ff @(posedge clk) begin
    if (start) begin
      st  <= din;
      ctr <= CTR_INIT;
    end else if (busy) begin
      st  <= perm_round(st, ctr);
      ctr <= ctr_next(ctr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= busy && !start && (rnd == RND_W'(ROUNDS - 1));
      if (start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        if (rnd == RND_W'(ROUNDS - 1)) begin
          busy <= 1'b0;
        end else begin
          rnd <= rnd + 1'b1;
        end
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("permutation restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a run");
  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    rnd < RND_W'(ROUNDS))
    else $error("round count out of range");

endmodule

/* rtl/eae_back.sv */
// Back end: mode sequencer, masks, tag sum and result register.
module eae_back (
  input  logic            clk,
  input  logic            rst,
  input  eae_pkg::cfg_t   cfg,
  input  logic            item_valid,
  output logic            item_ready,
  input  eae_pkg::item_t  item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_tag,
  output logic            out_last
);
  import eae_pkg::*;

  state_t state, state_next;
  phase_t phase;
  item_t  cur;

  logic [BLK_BITS-1:0] ek, adm, txm, tsum, ks, adb, cb;
  logic [FILL_W-1:0]   ad_fill, text_fill;
  logic [TAG_CNT_W-1:0] cnt;

  logic                perm_start, perm_busy, perm_done;
  logic [BLK_BITS-1:0] perm_din, perm_dout;

  logic                out_free;
  logic [BLK_BITS-1:0] adb_w, adb_pad, cb_w, cb_pad, txm1, txm2, mk, mc, tsum_n;
  logic [BLK_BITS-1:0] nonce_blk, key_blk;
  logic [7:0]          ks_byte, o_byte, c_byte;
  logic                ad_full, txt_full;

  eae_perm u_perm (
    .clk   (clk),
    .rst   (rst),
    .start (perm_start),
    .din   (perm_din),
    .busy  (perm_busy),
    .done  (perm_done),
    .dout  (perm_dout)
  );

  always_comb begin
    out_free  = !out_valid || out_ready;
    nonce_blk = {{(BLK_BITS - 8*NONCE_BYTES){1'b0}}, cfg.nonce};
    key_blk   = {{(BLK_BITS - 8*KEY_BYTES){1'b0}}, cfg.key};
    adb_w     = adb;
    adb_w[8*ad_fill +: 8] = cur.data;
    adb_pad   = pad_blk(adb, ad_fill);
    txm1      = lfsr_step(txm);
    txm2      = lfsr_step(txm1);
    mk        = txm ^ txm1;
    mc        = txm ^ txm2;
    ks_byte   = ks[8*text_fill +: 8];
    o_byte    = cur.data ^ ks_byte;
    c_byte    = cfg.decrypt ? cur.data : o_byte;
    cb_w      = cb;
    cb_w[8*text_fill +: 8] = c_byte;
    cb_pad    = pad_blk(cb, text_fill);
    tsum_n    = tsum ^ perm_dout ^ mc;
    ad_full   = (ad_fill == FILL_W'(BLK_BYTES - 1));
    txt_full  = (text_fill == FILL_W'(BLK_BYTES - 1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (item_valid) state_next = S_EXEC;
      S_EXEC: begin
        priority if (cur.op == OP_START) state_next = S_KEYP;
        else if (phase == PH_IDLE) state_next = S_IDLE;
        else if (cur.op == OP_AD) begin
          if (phase != PH_TEXT && ad_full && phase != PH_NONCE) state_next = S_ADP;
          else state_next = S_IDLE;
        end else if (phase == PH_AD) state_next = S_ADP;
        else state_next = S_DISP;
      end
      S_KEYP: if (perm_done) state_next = S_IDLE;
      S_ADP: if (perm_done) state_next = (cur.op == OP_AD) ? S_IDLE : S_DISP;
      S_DISP: begin
        if (cur.op == OP_FIN) state_next = S_CBP;
        else if (text_fill == '0) state_next = S_KSP;
        else state_next = S_TXT;
      end
      S_KSP: if (perm_done) state_next = S_TXT;
      S_TXT: if (out_free) state_next = txt_full ? S_CBP : S_IDLE;
      S_CBP: if (perm_done) state_next = (cur.op == OP_FIN) ? S_TGP : S_IDLE;
      S_TGP: if (perm_done) state_next = S_EMIT;
      S_EMIT: if (out_free && cnt == TAG_CNT_W'(TAG_BYTES - 1)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_ready = (state == S_IDLE);
    perm_start = 1'b0;
    perm_din   = adb_pad ^ adm;
    unique case (state)
      S_EXEC: begin
        if (cur.op == OP_START) begin
          perm_start = 1'b1;
          perm_din   = key_blk;
        end else if (phase == PH_AD) begin
          if (cur.op == OP_AD) begin
            perm_start = ad_full;
            perm_din   = adb_w ^ adm;
          end else begin
            perm_start = 1'b1;
            perm_din   = adb_pad ^ adm;
          end
        end
      end
      S_DISP: begin
        perm_start = (cur.op == OP_FIN) || (text_fill == '0);
        perm_din   = (cur.op == OP_FIN) ? (cb_pad ^ mc) : (nonce_blk ^ mk);
      end
      S_TXT: begin
        perm_start = out_free && txt_full;
        perm_din   = cb_w ^ mc;
      end
      S_CBP: begin
        perm_start = perm_done && (cur.op == OP_FIN);
        perm_din   = tsum_n ^ ek;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) cur <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      ad_fill   <= '0;
      text_fill <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      ek        <= '0;
      adm       <= '0;
      txm       <= '0;
      tsum      <= '0;
    end else begin
      if (out_valid && out_ready && state != S_TXT && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_EXEC: begin
          if (cur.op == OP_START) begin
          end else if (phase == PH_IDLE) begin
          end else if (cur.op == OP_AD) begin
            if (phase != PH_TEXT) begin
              adb     <= adb_w;
              ad_fill <= ad_full ? '0 : ad_fill + 1'b1;
              if (ad_full) begin
                if (phase == PH_NONCE) begin
                  tsum  <= tsum ^ adb_w;
                  adm   <= lfsr_step(adm);
                  phase <= PH_AD;
                end
              end
            end
          end else if (phase != PH_TEXT) begin
            adb     <= adb_pad;
            ad_fill <= '0;
            if (phase == PH_NONCE) begin
              tsum  <= tsum ^ adb_pad;
              adm   <= lfsr_step(adm);
              phase <= PH_TEXT;
            end
          end
        end
        S_KEYP: if (perm_done) begin
          ek        <= perm_dout;
          adm       <= perm_dout;
          txm       <= perm_dout;
          tsum      <= '0;
          adb       <= nonce_blk;
          ad_fill   <= FILL_W'(NONCE_BYTES);
          text_fill <= '0;
          phase     <= PH_NONCE;
        end
        S_ADP: if (perm_done) begin
          tsum <= tsum ^ perm_dout ^ adm;
          adm  <= lfsr_step(adm);
          if (cur.op != OP_AD) phase <= PH_TEXT;
        end
        S_KSP: if (perm_done) ks <= perm_dout ^ mk;
        S_TXT: if (out_free) begin
          out_valid <= 1'b1;
          out_byte  <= o_byte;
          out_tag   <= 1'b0;
          out_last  <= 1'b0;
          cb        <= cb_w;
          text_fill <= txt_full ? '0 : text_fill + 1'b1;
        end
        S_CBP: if (perm_done) begin
          tsum      <= tsum_n;
          txm       <= txm1;
          text_fill <= '0;
        end
        S_TGP: if (perm_done) begin
          tsum  <= perm_dout ^ ek;
          phase <= PH_IDLE;
          cnt   <= '0;
        end
        S_EMIT: if (out_free) begin
          out_valid <= 1'b1;
          out_byte  <= tsum[8*cnt +: 8];
          out_tag   <= 1'b1;
          out_last  <= (cnt == TAG_CNT_W'(TAG_BYTES - 1));
          cnt       <= cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_ad_fill: assert property (@(posedge clk) disable iff (rst)
    ad_fill < FILL_W'(BLK_BYTES))
    else $error("AD fill out of range");
  a_text_fill: assert property (@(posedge clk) disable iff (rst)
    text_fill < FILL_W'(BLK_BYTES))
    else $error("text fill out of range");
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (phase == PH_IDLE))
    else $error("tag emitted with message open");
  a_wait_perm: assert property (@(posedge clk) disable iff (rst)
    (state == S_TXT || state == S_EMIT) |-> !perm_busy)
    else $error("result written while permutation runs");

endmodule

/* tb/sv/tb.sv */
// Testbench for the Elephant AEAD engine: stream traffic checked beat by beat against a predictor.
`timescale 1ns / 100ps

import eae_pkg::*;

typedef struct {
  logic [7:0] data;
  logic       tag;
  logic       lst;
} out_beat_t;

class aead_scoreboard;
  logic [63:0]  key_lo, key_hi, nonce_lo;
  logic [31:0]  nonce_hi;
  logic         decrypt;
  logic [159:0] ekey, ad_msk, txt_msk, tsum, kstream, ad_blk, c_blk;
  int           ad_fill, txt_fill;
  phase_t       ph;
  out_beat_t    pending_q[$];
  int           errors, results, text_out, tags;

  function new();
    key_lo = '0; key_hi = '0; nonce_lo = '0; nonce_hi = '0; decrypt = 0;
    ekey = '0; ad_msk = '0; txt_msk = '0; tsum = '0; kstream = '0;
    ad_blk = '0; c_blk = '0; ad_fill = 0; txt_fill = 0; ph = PH_IDLE;
    errors = 0; results = 0; text_out = 0; tags = 0;
  endfunction

  function logic [3:0] sb4(input logic [3:0] x);
    logic [3:0] tbl [16];
    tbl = '{4'hE, 4'hD, 4'hB, 4'h0, 4'h2, 4'h1, 4'h4, 4'hF,
            4'h7, 4'hA, 4'h8, 4'h5, 4'h9, 4'hC, 4'h3, 4'h6};
    return tbl[x];
  endfunction

  function logic [159:0] spongent(input logic [159:0] s);
    logic [6:0]   c;
    logic [159:0] p;
    int           dst;
    c = 7'h75;
    for (int r = 0; r < 80; r++) begin
      s[7:0] = s[7:0] ^ {1'b0, c};
      for (int j = 0; j < 7; j++) s[159-j] = s[159-j] ^ c[j];
      c = {c[5:0], c[6] ^ c[5]};
      for (int i = 0; i < 40; i++) s[4*i +: 4] = sb4(s[4*i +: 4]);
      p = '0;
      for (int k = 0; k < 160; k++) begin
        dst = (k == 159) ? 159 : (k * 40) % 159;
        p[dst] = s[k];
      end
      s = p;
    end
    return s;
  endfunction

  function logic [159:0] mask_step(input logic [159:0] s);
    logic [159:0] t;
    logic [7:0]   b;
    t = s >> 8;
    b = s[7:0];
    t[159:152] = {b[4:0], b[7:5]} ^ {s[24], 7'b0} ^ {7'b0, s[111]};
    return t;
  endfunction

  function logic [159:0] pad(input logic [159:0] b, input int fill);
    if (fill < 20) begin
      b[8*fill +: 8] = PAD_BYTE;
      for (int i = fill + 1; i < 20; i++) b[8*i +: 8] = 8'h00;
    end
    return b;
  endfunction

  function logic [159:0] nonce_blk();
    return {64'b0, nonce_hi, nonce_lo};
  endfunction

  function void fold(input logic [159:0] b, input logic [159:0] m);
    tsum = tsum ^ spongent(b ^ m) ^ m;
  endfunction

  function void absorb_ad();
    if (ph == PH_NONCE) begin
      tsum = tsum ^ ad_blk;
      ph = PH_AD;
    end else begin
      fold(ad_blk, ad_msk);
    end
    ad_msk = mask_step(ad_msk);
  endfunction

  function void absorb_cipher();
    logic [159:0] m1, m2;
    m1 = mask_step(txt_msk);
    m2 = mask_step(m1);
    fold(c_blk, txt_msk ^ m2);
    txt_msk = m1;
  endfunction

  function void set_reg(input cfg_idx_t idx, input logic [63:0] v);
    case (idx)
      CFG_KEY_LO:   key_lo = v;
      CFG_KEY_HI:   key_hi = v;
      CFG_NONCE_LO: nonce_lo = v;
      CFG_NONCE_HI: nonce_hi = v[31:0];
      CFG_DECRYPT:  decrypt = v[0];
      default: ;
    endcase
  endfunction

  function void note_input(input op_t op, input logic [7:0] d);
    logic [159:0] m;
    logic [7:0]   o;
    if (op == OP_START) begin
      ekey = spongent({32'b0, key_hi, key_lo});
      ad_msk = ekey; txt_msk = ekey; tsum = '0;
      ad_blk = nonce_blk(); ad_fill = 12; txt_fill = 0; ph = PH_NONCE;
      return;
    end
    if (ph == PH_IDLE) return;
    if (op == OP_AD) begin
      if (ph == PH_TEXT || ad_fill >= 20) return;
      ad_blk[8*ad_fill +: 8] = d;
      ad_fill++;
      if (ad_fill == 20) begin
        absorb_ad();
        ad_fill = 0;
      end
      return;
    end
    if (ph != PH_TEXT) begin
      ad_blk = pad(ad_blk, ad_fill);
      absorb_ad();
      ad_fill = 0;
      ph = PH_TEXT;
    end
    if (op == OP_TEXT) begin
      if (txt_fill >= 20) txt_fill = 0;
      if (txt_fill == 0) begin
        m = txt_msk ^ mask_step(txt_msk);
        kstream = spongent(nonce_blk() ^ m) ^ m;
      end
      o = d ^ kstream[8*txt_fill +: 8];
      c_blk[8*txt_fill +: 8] = decrypt ? d : o;
      txt_fill++;
      if (txt_fill == 20) begin
        absorb_cipher();
        txt_fill = 0;
      end
      pending_q.push_back('{o, 1'b0, 1'b0});
      return;
    end
    c_blk = pad(c_blk, txt_fill);
    absorb_cipher();
    txt_fill = 0;
    tsum = spongent(tsum ^ ekey) ^ ekey;
    ph = PH_IDLE;
    for (int i = 0; i < TAG_BYTES; i++)
      pending_q.push_back('{tsum[8*i +: 8], 1'b1, i == TAG_BYTES - 1});
  endfunction

  function void check(input logic [7:0] d, input logic tg, input logic ls);
    out_beat_t e;
    results++;
    if (pending_q.size() == 0) begin
      $error("unexpected output beat data=%h is_tag=%b last=%b", d, tg, ls);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (e.tag) tags++; else text_out++;
    if (d !== e.data) begin
      $error("out_byte: expected %h, got %h", e.data, d);
      errors++;
    end
    if (tg !== e.tag) begin
      $error("is_tag: expected %b, got %b", e.tag, tg);
      errors++;
    end
    if (ls !== e.lst) begin
      $error("last: expected %b, got %b", e.lst, ls);
      errors++;
    end
  endfunction

  function int pending();
    return pending_q.size();
  endfunction
endclass

module tb;
  localparam int        LIMIT      = 1000000;
  localparam logic [2:0] CFG_SPARE = 3'd7;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aead_scoreboard sb = new();
  int          send_idle = 0;
  int          stall_pct = 0;
  int          accepted = 0;
  int          cycles = 0;
  int          msgs = 0;

  elephant_aead_engine dut (.*);

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata, m_tuser[0], m_tlast);
  end

  task automatic send(input op_t op, input logic [7:0] d);
    if ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, d);
    accepted++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(cfg_idx_t'(idx), v);
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic message(input int nad, input int ntxt, input int noise);
    send(OP_START, $urandom_range(0, 255));
    for (int i = 0; i < nad; i++) send(OP_AD, $urandom_range(0, 255));
    for (int i = 0; i < ntxt; i++) begin
      if ($urandom_range(0, 99) < noise) send(op_t'($urandom_range(1, 2)), $urandom_range(0, 255));
      else send(OP_TEXT, $urandom_range(0, 255));
    end
    send(OP_FIN, $urandom_range(0, 255));
    msgs++;
  endtask

  initial begin
    int idle_set [4];
    int stall_set[4];
    int quota;
    int nad;
    int ntxt;
    idle_set  = '{0, 83, 0, 30};
    stall_set = '{0, 0, 83, 30};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_set[ph];
      stall_pct = stall_set[ph];
      if (ph == 0) begin
        write_reg(CFG_KEY_LO, '1);
        write_reg(CFG_KEY_HI, '1);
        write_reg(CFG_NONCE_LO, '1);
        write_reg(CFG_NONCE_HI, 64'hFFFF_FFFF);
        write_reg(CFG_DECRYPT, 0);
        write_reg(CFG_SPARE, '1);
      end else if (ph == 1) begin
        write_reg(CFG_KEY_LO, '0);
        write_reg(CFG_KEY_HI, '0);
        write_reg(CFG_NONCE_LO, '0);
        write_reg(CFG_NONCE_HI, '0);
        write_reg(CFG_DECRYPT, 1);
      end else begin
        write_reg(CFG_KEY_LO, {$urandom, $urandom});
        write_reg(CFG_KEY_HI, {$urandom, $urandom});
        write_reg(CFG_NONCE_LO, {$urandom, $urandom});
        write_reg(CFG_NONCE_HI, {32'b0, $urandom});
        write_reg(CFG_DECRYPT, $urandom_range(0, 1));
      end

      if (ph == 0) begin
        // ignored while idle, then AD filling the nonce block exactly
        send(OP_TEXT, 8'hFF);
        send(OP_AD, 8'h00);
        send(OP_FIN, 8'h00);
        send(OP_START, 8'h00);
        for (int i = 0; i < 8; i++) send(OP_AD, (i % 2) ? 8'hFF : 8'h00);
        send(OP_TEXT, 8'h00);
        send(OP_TEXT, 8'hFF);
        send(OP_AD, 8'hA5);
        send(OP_TEXT, 8'h5A);
        send(OP_FIN, 8'hFF);
        // finish with no text, then a restart mid-message
        send(OP_START, 8'hFF);
        send(OP_FIN, 8'h00);
        send(OP_START, 8'h00);
        send(OP_AD, 8'h3C);
        send(OP_TEXT, 8'hC3);
        send(OP_START, 8'h00);
        send(OP_FIN, 8'h00);
        drain();
      end

      quota = accepted + 66;
      while (accepted < quota) begin
        if ($urandom_range(0, 99) < 8) begin
          send(op_t'($urandom_range(1, 3)), $urandom_range(0, 255));
        end else begin
          nad  = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 10) : $urandom_range(0, 30);
          ntxt = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 22) : $urandom_range(0, 45);
          message(nad, ntxt, 5);
        end
      end
      drain();
    end

    if (sb.pending() != 0) begin
      $error("%0d expected beats never arrived", sb.pending());
      sb.errors++;
    end
    $display("%0d items in, %0d messages over 4 handshake mixes and 4 key/nonce settings",
             accepted, msgs);
    $display("%0d text beats and %0d tag beats checked", sb.text_out, sb.tags);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
